FILE: design/assert_macros.svh
// Assertion helpers for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication: when ante holds, cons must hold too.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/mpfl_pkg.sv
package mpfl_pkg;

    localparam int SLOTS_PER_POOL_DEF = 1024;
    localparam int NUM_POOLS_DEF      = 4;

    // fixed field widths
    localparam int KIND_W     = 1;
    localparam int POOL_IDX_W = 2;
    localparam int SLOT_IDX_W = 10;
    localparam int STATUS_W   = 2;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FREED     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;

endpackage

FILE: design/mpfl_link_ram.sv
// Link RAM: one write port, one read port, registered read data.
module mpfl_link_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 10
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/multi_pool_free_list_allocator.sv
// Fixed-slot allocator over NUM_POOLS pools of SLOTS_PER_POOL slots each.
// Request channel (req_valid / req_stall): kind 0 allocates, kind 1 frees
// the slot given by pool_index / slot_index. Result channel (res_valid /
// res_stall): status 0 allocated (granted_pool / granted_slot), 1 freed,
// 2 all pools exhausted. Exactly one result per request, in order.
// Allocation takes the lowest pool with a slot: its freed list first (LIFO),
// then never-used slots in ascending order. Frees are not checked for
// doubles; an out-of-range pool or slot is ignored but still answered.
// Timing: the accept cycle issues the link RAM read at the freed-list head;
// the done state uses the registered read data to move the head and
// writes the result register. Requests are not taken while the block is in
// the done state, so the link RAM read-modify-write finishes before the
// next request. A request is taken while an old result still waits;
// a stalled result holds the block in its done state until taken.
// Reset empties every freed list and zeroes the fresh counters; the link
// RAM needs no clearing, so the block is ready right after reset.
module multi_pool_free_list_allocator #(
    parameter int SLOTS_PER_POOL = mpfl_pkg::SLOTS_PER_POOL_DEF,
    parameter int NUM_POOLS      = mpfl_pkg::NUM_POOLS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [mpfl_pkg::KIND_W-1:0]       kind,
    input  logic [mpfl_pkg::POOL_IDX_W-1:0]   pool_index,
    input  logic [mpfl_pkg::SLOT_IDX_W-1:0]   slot_index,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [mpfl_pkg::STATUS_W-1:0]     status,
    output logic [mpfl_pkg::POOL_IDX_W-1:0]   granted_pool,
    output logic [mpfl_pkg::SLOT_IDX_W-1:0]   granted_slot
);

    localparam int POOL_IDX_W = mpfl_pkg::POOL_IDX_W;
    localparam int SLOT_IDX_W = mpfl_pkg::SLOT_IDX_W;
    localparam int STATUS_W   = mpfl_pkg::STATUS_W;
    localparam int KIND_W     = mpfl_pkg::KIND_W;

    localparam int POOL_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int SLOT_W = $clog2(SLOTS_PER_POOL);
    localparam int CNT_W  = $clog2(SLOTS_PER_POOL + 1);
    localparam int ADDR_W = POOL_W + SLOT_W;

    // sequencer codes
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DONE = 1'b1;

    logic state_reg, state_next;

    // per-pool list state
    logic [SLOT_W-1:0] freed_head_reg     [NUM_POOLS];
    logic              freed_nonempty_reg [NUM_POOLS];
    logic [CNT_W-1:0]  fresh_count_reg    [NUM_POOLS];

    // request latched at accept
    logic [KIND_W-1:0] kind_reg;
    logic [POOL_W-1:0] pool_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] val_reg;      // link to write (free) or slot granted (alloc)
    logic              hit_reg;      // free in range, or a pool had a slot
    logic              from_freed_reg;

    // result register
    logic                  res_valid_reg;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [POOL_IDX_W-1:0] granted_pool_reg, granted_pool_next;
    logic [SLOT_IDX_W-1:0] granted_slot_reg, granted_slot_next;

    logic req_fire;
    logic out_free;
    logic done_fire;

    logic [31:0]       pool_wide;
    logic [31:0]       slot_wide;
    logic [POOL_W-1:0] pool_in;
    logic [SLOT_W-1:0] slot_in;
    logic              free_ok;

    logic              pick_found;
    logic [POOL_W-1:0] pick_pool;
    logic [POOL_W-1:0] sel_idx;
    logic [SLOT_W-1:0] head_rd;
    logic              nonempty_rd;
    logic [CNT_W-1:0]  fresh_rd;
    logic [SLOT_W-1:0] got_slot;
    logic [SLOT_W-1:0] link_val;

    logic [31:0]       pool_out_wide;
    logic [31:0]       slot_out_wide;

    logic              ram_wr_en;
    logic [SLOT_W-1:0] ram_rd_data;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign done_fire = (state_reg == ST_DONE) && out_free;

    // request fields at internal widths
    assign pool_wide = 32'(pool_index);
    assign slot_wide = 32'(slot_index);
    assign pool_in   = pool_wide[POOL_W-1:0];
    assign slot_in   = slot_wide[SLOT_W-1:0];
    assign free_ok   = (pool_wide < 32'(NUM_POOLS)) && (slot_wide < 32'(SLOTS_PER_POOL));

    // lowest pool with a freed or fresh slot
    always_comb
    begin
        pick_found = 1'b0;
        pick_pool  = '0;
        for (int i = 0; i < NUM_POOLS; i++)
        begin
            if (!pick_found &&
                (freed_nonempty_reg[i] || fresh_count_reg[i] < CNT_W'(SLOTS_PER_POOL)))
            begin
                pick_found = 1'b1;
                pick_pool  = POOL_W'(i);
            end
        end
    end

    assign sel_idx     = (kind == mpfl_pkg::KIND_FREE) ? pool_in : pick_pool;
    assign head_rd     = freed_head_reg[sel_idx];
    assign nonempty_rd = freed_nonempty_reg[sel_idx];
    assign fresh_rd    = fresh_count_reg[pick_pool];
    assign got_slot    = nonempty_rd ? head_rd : fresh_rd[SLOT_W-1:0];
    // a slot pushed onto an empty list links to itself (end marker)
    assign link_val    = nonempty_rd ? head_rd : slot_in;

    assign ram_wr_en = done_fire && (kind_reg == mpfl_pkg::KIND_FREE) && hit_reg;

    mpfl_link_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (SLOT_W)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr ({pool_reg, slot_reg}),
        .wr_data (val_reg),
        .rd_en   (req_fire),
        .rd_addr ({pick_pool, head_rd}),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // latch request and lookup at accept
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg       <= kind;
            hit_reg        <= (kind == mpfl_pkg::KIND_FREE) ? free_ok : pick_found;
            pool_reg       <= sel_idx;
            slot_reg       <= slot_in;
            val_reg        <= (kind == mpfl_pkg::KIND_FREE) ? link_val : got_slot;
            from_freed_reg <= nonempty_rd;
        end
    end

    // list state update in the done state, when the result is written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_POOLS; i++)
            begin
                freed_head_reg[i]     <= '0;
                freed_nonempty_reg[i] <= 1'b0;
                fresh_count_reg[i]    <= '0;
            end
        end
        else if (done_fire && hit_reg)
        begin
            if (kind_reg == mpfl_pkg::KIND_FREE)
            begin
                freed_head_reg[pool_reg]     <= slot_reg;
                freed_nonempty_reg[pool_reg] <= 1'b1;
            end
            else if (from_freed_reg)
            begin
                // popped slot linking to itself was the last one
                if (ram_rd_data == val_reg)
                begin
                    freed_nonempty_reg[pool_reg] <= 1'b0;
                end
                else
                begin
                    freed_head_reg[pool_reg] <= ram_rd_data;
                end
            end
            else
            begin
                fresh_count_reg[pool_reg] <= CNT_W'(val_reg) + CNT_W'(1);
            end
        end
    end

    assign pool_out_wide = 32'(pool_reg);
    assign slot_out_wide = 32'(val_reg);

    always_comb
    begin
        status_next       = mpfl_pkg::STATUS_FREED;
        granted_pool_next = '0;
        granted_slot_next = '0;
        if (kind_reg == mpfl_pkg::KIND_ALLOC)
        begin
            if (hit_reg)
            begin
                status_next       = mpfl_pkg::STATUS_ALLOCATED;
                granted_pool_next = pool_out_wide[POOL_IDX_W-1:0];
                granted_slot_next = slot_out_wide[SLOT_IDX_W-1:0];
            end
            else
            begin
                status_next = mpfl_pkg::STATUS_EXHAUSTED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (done_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            status_reg       <= status_next;
            granted_pool_reg <= granted_pool_next;
            granted_slot_reg <= granted_slot_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign status       = status_reg;
    assign granted_pool = granted_pool_reg;
    assign granted_slot = granted_slot_reg;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_accept_to_done, clk, rst_n, req_fire, state_reg == ST_DONE)
    `ASSERT_IMPLIES(a_exhaust_real, clk, rst_n, done_fire && kind_reg == mpfl_pkg::KIND_ALLOC && !hit_reg, !pick_found)
    `ASSERT_IMPLIES(a_grant_zero, clk, rst_n, res_valid_reg && status_reg != mpfl_pkg::STATUS_ALLOCATED, granted_pool_reg == '0 && granted_slot_reg == '0)

endmodule
